// File: rtl/sdlw_pkg.sv
`timescale 1ns / 1ps

package sdlw_pkg;

  localparam int LINE_CHARS  = 16;
  localparam int MAG_W       = 32;
  localparam int DIGITS      = 10;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int NDIG_W      = $clog2(DIGITS + 1);
  localparam int CUR_W       = $clog2(LINE_CHARS + DIGITS + 2);
  localparam int GOTO_W      = $clog2(LINE_CHARS);

  localparam logic [7:0] ADDR_FLAG   = 8'h80;
  localparam logic [7:0] LINE_OFFSET = 8'd64;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_MINUS  = 8'h2d;

  typedef struct packed {
    logic signed [31:0] number;
    logic [7:0]         column;
    logic [7:0]         line;
  } req_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_ADDR,
    ST_BAD,
    ST_CHAR,
    ST_GOTO,
    ST_WRAP
  } state_t;

endpackage

// File: rtl/signed_decimal_lcd_writer.sv
`timescale 1ns / 1ps

// Signed decimal writer for a two-line character display.
// Request channel (req_valid / req_stall / req) carries a signed 32-bit
// number and a start column and line. Response channel (rsp_valid /
// rsp_stall / rsp) carries the display bus writes, one per transfer:
// a set-address command, then '-' if negative, then the decimal digits
// most significant first, with a go-to command on the second line after
// each character that leaves the cursor at or past the end of a line.
// last marks the final write of a request. A bad position gives only
// the command for position (0,0).
// The magnitude goes through a shift-and-add-3 binary to BCD unit, one
// bit per cycle, then leading zero digits are dropped (up to 9), then
// the writes go out one by one. With no stall the first write is loaded
// later for fewer digits; a bad position skips the conversion.
// req_stall is high from the request transfer until the final write is
// loaded into the output register.
// A stalled response holds; the sequencer waits on it.
// Reset empties the output register and returns the sequencer to idle.
module signed_decimal_lcd_writer
  import sdlw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t state, state_next;

  logic [MAG_W-1:0]  mag;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [CNT_W-1:0]  cnt;
  logic [NDIG_W-1:0] ndig;
  logic [CUR_W-1:0]  cursor;
  logic [CUR_W-1:0]  cursor_inc;
  logic [GOTO_W-1:0] goto_col;
  logic              line_hi;
  logic              sign_pending;

  logic req_go;
  logic pos_ok;
  logic emit_valid;
  logic emit_go;
  rsp_t emit_item;

  logic top_zero;
  logic goto_need;
  logic goto_wrap;
  logic more_chars;
  logic chars_left;

  assign req_stall = (state != ST_IDLE);
  assign req_go    = req_valid && !req_stall;
  assign pos_ok    = (req.column <= 8'(LINE_CHARS - 1)) && (req.line <= 8'd1);
  assign emit_go   = emit_valid && (!rsp_valid || !rsp_stall);

  assign top_zero   = (bcd[BCD_W-1 -: 4] == 4'd0);
  assign cursor_inc = cursor + CUR_W'(1);
  assign goto_need  = (cursor_inc >= CUR_W'(LINE_CHARS));
  assign goto_wrap  = (goto_col == GOTO_W'(LINE_CHARS - 1));
  // characters still due after the one in flight
  assign more_chars = sign_pending || (ndig > NDIG_W'(1));
  // characters still due once the last one has gone out
  assign chars_left = (ndig != '0);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_go) begin
          state_next = pos_ok ? ST_CONV : ST_BAD;
        end
      end
      ST_CONV: begin
        if (cnt == CNT_W'(MAG_W - 1)) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!(top_zero && (ndig > NDIG_W'(1)))) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (emit_go) begin
          state_next = ST_CHAR;
        end
      end
      ST_BAD: begin
        if (emit_go) begin
          state_next = ST_IDLE;
        end
      end
      ST_CHAR: begin
        if (emit_go) begin
          if (goto_need) begin
            state_next = ST_GOTO;
          end else if (more_chars) begin
            state_next = ST_CHAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_GOTO: begin
        if (emit_go) begin
          if (goto_wrap) begin
            state_next = ST_WRAP;
          end else if (chars_left) begin
            state_next = ST_CHAR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WRAP: begin
        if (emit_go) begin
          state_next = chars_left ? ST_CHAR : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_valid = 1'b0;
    emit_item  = '0;
    case (state)
      ST_ADDR: begin
        emit_valid         = 1'b1;
        emit_item.bus_byte = ADDR_FLAG | 8'(cursor) | (line_hi ? LINE_OFFSET : 8'd0);
      end
      ST_BAD: begin
        emit_valid         = 1'b1;
        emit_item.bus_byte = ADDR_FLAG;
        emit_item.last     = 1'b1;
      end
      ST_CHAR: begin
        emit_valid         = 1'b1;
        emit_item.is_data  = 1'b1;
        emit_item.bus_byte = sign_pending ? CHAR_MINUS
                                          : (CHAR_ZERO | {4'd0, bcd[BCD_W-1 -: 4]});
        emit_item.last     = !goto_need && !more_chars;
      end
      ST_GOTO: begin
        emit_valid         = 1'b1;
        emit_item.bus_byte = ADDR_FLAG | LINE_OFFSET | 8'(goto_col);
        emit_item.last     = !goto_wrap && !chars_left;
      end
      ST_WRAP: begin
        emit_valid         = 1'b1;
        emit_item.bus_byte = ADDR_FLAG;
        emit_item.last     = !chars_left;
      end
      default: begin
        emit_valid = 1'b0;
        emit_item  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      rsp <= emit_item;
    end
    case (state)
      ST_IDLE: begin
        if (req_go) begin
          mag          <= req.number[31] ? (MAG_W'(0) - MAG_W'(req.number))
                                         : MAG_W'(req.number);
          sign_pending <= req.number[31];
          cursor       <= CUR_W'(req.column);
          line_hi      <= req.line[0];
          bcd          <= '0;
          cnt          <= '0;
          ndig         <= NDIG_W'(DIGITS);
          goto_col     <= '0;
        end
      end
      ST_CONV: begin
        {bcd, mag} <= {bcd_adj[BCD_W-2:0], mag, 1'b0};
        cnt        <= cnt + CNT_W'(1);
      end
      ST_SKIP: begin
        if (top_zero && (ndig > NDIG_W'(1))) begin
          bcd  <= {bcd[BCD_W-5:0], 4'd0};
          ndig <= ndig - NDIG_W'(1);
        end
      end
      ST_CHAR: begin
        if (emit_go) begin
          cursor <= cursor_inc;
          if (sign_pending) begin
            sign_pending <= 1'b0;
          end else begin
            bcd  <= {bcd[BCD_W-5:0], 4'd0};
            ndig <= ndig - NDIG_W'(1);
          end
        end
      end
      ST_GOTO: begin
        if (emit_go) begin
          goto_col <= goto_wrap ? '0 : goto_col + GOTO_W'(1);
        end
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_bad_pos: assert property (@(posedge clk) disable iff (rst)
    (req_go && !pos_ok) |=> (state == ST_BAD))
    else $error("bad position did not go to the single address write");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_item.last) |=> (state == ST_IDLE))
    else $error("sequencer kept running after the final write");

  a_char_due: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHAR) |-> (sign_pending || (ndig != '0)))
    else $error("character write with no character left");

  a_digit_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHAR && !sign_pending) |-> (bcd[BCD_W-1 -: 4] <= 4'd9))
    else $error("decimal digit out of range");
`endif

endmodule
